>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an antecedent implies a consequent on the same edge.
`define ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Assert that an antecedent implies a consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> rtl/lfsc_pkg.sv
// Package for the line-follow steering controller: widths, codes, constants.
// No dependencies.
`default_nettype none
package lfsc_pkg;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int THR_W = 12;
    localparam int GAIN_W = 20;
    localparam int CFG_W = 20;
    localparam int VEL_W = 25;
    localparam int CLS_W = 4;
    localparam int ERR_W = 19;
    localparam int SUM_W = 32;
    localparam int RAT_W = 21;
    localparam int ACC_W = 56;

    localparam logic [1:0] REG_THR = 2'd0;
    localparam logic [1:0] REG_KP = 2'd1;
    localparam logic [1:0] REG_KI = 2'd2;
    localparam logic [1:0] REG_KD = 2'd3;

    localparam logic [3:0] CLS_MID = 4'd0;
    localparam logic [3:0] CLS_LEFT = 4'd1;
    localparam logic [3:0] CLS_RIGHT = 4'd2;
    localparam logic [3:0] CLS_FULL = 4'd3;
    localparam logic [3:0] CLS_BLANK = 4'd4;
    localparam logic [3:0] CLS_L90 = 4'd5;
    localparam logic [3:0] CLS_R90 = 4'd6;
    localparam logic [3:0] CLS_XL = 4'd7;
    localparam logic [3:0] CLS_XR = 4'd8;
    localparam logic [3:0] CLS_CIRCLE = 4'd9;

    localparam logic [1:0] HEAD_NONE = 2'd0;
    localparam logic [1:0] HEAD_MID = 2'd1;
    localparam logic [1:0] HEAD_L90 = 2'd2;
    localparam logic [1:0] HEAD_R90 = 2'd3;

    // Ratio codes chosen by the mode machine.
    localparam logic [2:0] RSEL_HOLD = 3'd0;
    localparam logic [2:0] RSEL_STOP = 3'd1;
    localparam logic [2:0] RSEL_LEFT = 3'd2;
    localparam logic [2:0] RSEL_RIGHT = 3'd3;
    localparam logic [2:0] RSEL_FWD = 3'd4;
    localparam logic [2:0] RSEL_PID = 3'd5;

    typedef struct packed {
        logic load;      // capture samples, classify
        logic mul_p;     // form Kp*e
        logic mul_i;     // add Ki*s
        logic mul_d;     // add Kd*d
        logic commit;    // update state, load result
    } lfsc_cmd_t;
endpackage
`default_nettype wire

>>> rtl/lfsc_if.sv
// Valid/ready channel interfaces for samples and results.
// No dependencies.
`default_nettype none
interface lfsc_in_if #(parameter int SAMPLE_BITS = 12);
    logic valid;
    logic ready;
    logic [SAMPLE_BITS-1:0] sample_0, sample_1, sample_2, sample_3;
    logic [SAMPLE_BITS-1:0] sample_4, sample_5, sample_6, sample_7;
    modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                    sample_4, sample_5, sample_6, sample_7, input ready);
    modport sink (input valid, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface lfsc_out_if;
    logic valid;
    logic ready;
    logic signed [24:0] left_velocity;
    logic signed [24:0] right_velocity;
    logic [3:0] line_class;
    modport source (output valid, left_velocity, right_velocity, line_class,
                    input ready);
    modport sink (input valid, left_velocity, right_velocity, line_class,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/line_follow_steering_controller.sv
// Line-follow steering controller. One beat in gives one beat out; after
// acceptance the sequencer steps through capture and classify, three multiply-
// accumulate steps on one shared gain multiplier, and commit, and the result
// is then valid. No new beat is taken until the sequencer is back in idle, and
// a result still waiting holds off the next beat. Configuration writes take
// effect at once and must only come while the block is idle.
`default_nettype none
module line_follow_steering_controller
    import lfsc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    lfsc_in_if.sink   in_ch,
    lfsc_out_if.source out_ch,
    input  wire logic cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);
    logic [THR_W-1:0] thr_reg;
    logic [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    lfsc_cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(300);
            kp_reg <= GAIN_W'(124518);
            ki_reg <= GAIN_W'(655);
            kd_reg <= GAIN_W'(66);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THR: thr_reg <= cfg_data[THR_W-1:0];
                REG_KP: kp_reg <= cfg_data;
                REG_KI: ki_reg <= cfg_data;
                REG_KD: kd_reg <= cfg_data;
                default: thr_reg <= thr_reg;
            endcase
        end
    end

    lfsc_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .cmd(cmd)
    );

    lfsc_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .samples({in_ch.sample_7, in_ch.sample_6, in_ch.sample_5, in_ch.sample_4,
                  in_ch.sample_3, in_ch.sample_2, in_ch.sample_1, in_ch.sample_0}),
        .thr(thr_reg),
        .kp(kp_reg),
        .ki(ki_reg),
        .kd(kd_reg),
        .cmd(cmd),
        .left_velocity(out_ch.left_velocity),
        .right_velocity(out_ch.right_velocity),
        .line_class(out_ch.line_class)
    );
endmodule
`default_nettype wire

>>> rtl/lfsc_ctrl.sv
// Sequencer: accept a beat, step the datapath through the PID, hand off result.
// Depends on lfsc_pkg.
`default_nettype none
module lfsc_ctrl
    import lfsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output lfsc_cmd_t cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_P = 3'd1;
    localparam logic [2:0] S_I = 3'd2;
    localparam logic [2:0] S_D = 3'd3;
    localparam logic [2:0] S_C = 3'd4;

    logic [2:0] state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // Result register frees on take, so a new beat can enter as the waiting result is taken.
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    state_next = S_P;
                end
            end
            S_P:
            begin
                cmd.mul_p = 1'b1;
                state_next = S_I;
            end
            S_I:
            begin
                cmd.mul_i = 1'b1;
                state_next = S_D;
            end
            S_D:
            begin
                cmd.mul_d = 1'b1;
                state_next = S_C;
            end
            S_C:
            begin
                cmd.commit = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

>>> rtl/lfsc_dp.sv
// Datapath: threshold, centroid, classification, shared PID multiplier,
// mode flags and held ratios. Depends on lfsc_pkg.
`default_nettype none
module lfsc_dp
    import lfsc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic [8*SAMPLE_BITS-1:0] samples,
    input  wire logic [THR_W-1:0] thr,
    input  wire logic [GAIN_W-1:0] kp,
    input  wire logic [GAIN_W-1:0] ki,
    input  wire logic [GAIN_W-1:0] kd,
    input  wire lfsc_cmd_t cmd,
    output logic signed [VEL_W-1:0] left_velocity,
    output logic signed [VEL_W-1:0] right_velocity,
    output logic [CLS_W-1:0] line_class
);
    logic [7:0] on;
    logic [4:0] sum;
    logic [3:0] cnt;
    logic lt, gt;
    logic [3:0] cls;
    logic [CLS_W-1:0] cls_reg;
    logic signed [ERR_W-1:0] e_reg;
    logic signed [SUM_W-1:0] s_new_reg;
    logic signed [ERR_W:0] d_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [SUM_W-1:0] error_sum_reg;
    logic signed [ERR_W-1:0] last_error_reg;
    logic signed [RAT_W-1:0] left_reg, right_reg, left_next, right_next;
    logic cla_reg, cra_reg, tl_reg, tr_reg, circ_reg;
    logic cla_next, cra_next, tl_next, tr_next, circ_next;
    logic [1:0] head_reg, head_next;
    logic [2:0] rsel;
    logic [20:0] quot;
    logic signed [ERR_W-1:0] e_calc;
    logic signed [SUM_W:0] s_wide;
    logic signed [SUM_W-1:0] s_sat;
    logic signed [ACC_W-1:0] ctl;
    logic signed [RAT_W-1:0] ctl_c;
    logic signed [ACC_W-1:0] prod;

    always_comb
    begin
        sum = '0;
        cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            on[i] = 16'(samples[i*SAMPLE_BITS +: SAMPLE_BITS]) < 16'(thr);
            if (on[i])
            begin
                sum = sum + 5'(i);
                cnt = cnt + 4'd1;
            end
        end
        lt = (cnt == 4'd0) || ({2'b0, sum, 1'b0} < 8'(7 * cnt));
        gt = (cnt != 4'd0) && ({2'b0, sum, 1'b0} > 8'(9 * cnt));
        cls = CLS_MID;
        if (lt)
            cls = CLS_LEFT;
        else if (gt)
            cls = CLS_RIGHT;
        if (cnt == 4'd0) cls = CLS_BLANK;
        if (cnt == 4'd8) cls = CLS_FULL;
        if (lt && on[0] && on[1] && on[2] && !on[6] && !on[7]) cls = CLS_L90;
        if (gt && on[7] && on[6] && on[5] && !on[1] && !on[0]) cls = CLS_R90;
        if (gt && on[7:1] == 7'b1000000) cls = CLS_XR;
        if (lt && on[5:0] == 6'b000001) cls = CLS_XL;
        if (!on[7] && on[5] && on[4] && on[3] && on[2] && !on[0]) cls = CLS_CIRCLE;
        // Centroid: sum*65536/cnt, sum <= 28, cnt <= 8; reciprocal multiply for counts 3, 5, 6, 7, shifts otherwise.
        unique case (cnt)
            4'd1: quot = {sum, 16'd0};
            4'd2: quot = {1'b0, sum, 15'd0};
            4'd3: quot = 21'((44'({sum, 16'd0}) * 44'd2796203) >> 23);
            4'd4: quot = {2'b0, sum, 14'd0};
            4'd5: quot = 21'((44'({sum, 16'd0}) * 44'd1677722) >> 23);
            4'd6: quot = 21'((44'({sum, 16'd0}) * 44'd2796203) >> 24);
            4'd7: quot = 21'((44'({sum, 16'd0}) * 44'd1198373) >> 23);
            4'd8: quot = {3'b0, sum, 13'd0};
            default: quot = '0;
        endcase
        e_calc = ERR_W'(229376) - ERR_W'(signed'({1'b0, quot}));
        s_wide = 33'(error_sum_reg) + 33'(e_calc);
        if (s_wide > 33'sh07FFFFFFF)
            s_sat = 32'sh7FFFFFFF;
        else if (s_wide < -33'sh080000000)
            s_sat = 32'sh80000000;
        else
            s_sat = s_wide[SUM_W-1:0];
    end

    always_comb
    begin
        prod = '0;
        acc_next = acc_reg;
        if (cmd.mul_p)
        begin
            prod = ACC_W'(signed'({1'b0, kp})) * ACC_W'(e_reg);
            acc_next = prod;
        end
        else if (cmd.mul_i)
        begin
            prod = ACC_W'(signed'({1'b0, ki})) * ACC_W'(s_new_reg);
            acc_next = acc_reg + prod;
        end
        else if (cmd.mul_d)
        begin
            prod = ACC_W'(signed'({1'b0, kd})) * ACC_W'(d_reg);
            acc_next = acc_reg + prod;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cls_reg <= cls;
            e_reg <= e_calc;
            s_new_reg <= s_sat;
            d_reg <= (ERR_W+1)'(e_calc) - (ERR_W+1)'(last_error_reg);
        end
        acc_reg <= acc_next;
    end

    always_comb
    begin
        ctl = acc_reg >>> 16;
        if (ctl > ACC_W'(786432))
            ctl_c = RAT_W'(786432);
        else if (ctl < -ACC_W'(786432))
            ctl_c = -RAT_W'(786432);
        else
            ctl_c = ctl[RAT_W-1:0];
        cla_next = cla_reg;
        cra_next = cra_reg;
        tl_next = tl_reg;
        tr_next = tr_reg;
        circ_next = circ_reg;
        head_next = head_reg;
        rsel = RSEL_HOLD;
        priority if (tl_reg)
        begin
            if (cls_reg == CLS_XL)
            begin
                tl_next = 1'b0;
                cla_next = 1'b0;
                cra_next = 1'b0;
                rsel = RSEL_STOP;
            end
            else
                rsel = RSEL_LEFT;
        end
        else if (tr_reg)
        begin
            if (cls_reg == CLS_XR)
            begin
                tr_next = 1'b0;
                cla_next = 1'b0;
                cra_next = 1'b0;
                rsel = RSEL_STOP;
            end
            else
                rsel = RSEL_RIGHT;
        end
        else if (cls_reg == CLS_MID)
        begin
            head_next = HEAD_MID;
            rsel = RSEL_FWD;
        end
        else if (cls_reg == CLS_LEFT || cls_reg == CLS_XL || cls_reg == CLS_RIGHT
                 || cls_reg == CLS_XR)
            rsel = RSEL_PID;
        else if (cls_reg == CLS_L90)
        begin
            cla_next = 1'b1;
            cra_next = 1'b0;
            head_next = HEAD_L90;
        end
        else if (cls_reg == CLS_R90)
        begin
            cra_next = 1'b1;
            cla_next = 1'b0;
            head_next = HEAD_R90;
        end
        else if (cls_reg == CLS_CIRCLE)
            circ_next = 1'b1;
        else if (cls_reg == CLS_BLANK && head_reg == HEAD_L90)
        begin
            cla_next = 1'b0;
            cra_next = 1'b0;
            rsel = RSEL_LEFT;
        end
        else if (cls_reg == CLS_BLANK && head_reg == HEAD_R90)
        begin
            cla_next = 1'b0;
            cra_next = 1'b0;
            rsel = RSEL_RIGHT;
        end
        else if (cls_reg == CLS_BLANK && head_reg == HEAD_MID)
            rsel = RSEL_FWD;
        else if (cls_reg == CLS_BLANK && circ_reg)
            rsel = RSEL_RIGHT;
        else if (cls_reg == CLS_FULL && cla_reg)
        begin
            tl_next = 1'b1;
            rsel = RSEL_STOP;
        end
        else if (cls_reg == CLS_FULL && cra_reg)
        begin
            tr_next = 1'b1;
            rsel = RSEL_STOP;
        end
        unique case (rsel)
            RSEL_STOP:
            begin
                left_next = '0;
                right_next = '0;
            end
            RSEL_LEFT:
            begin
                left_next = '0;
                right_next = RAT_W'(131072);
            end
            RSEL_RIGHT:
            begin
                left_next = RAT_W'(131072);
                right_next = '0;
            end
            RSEL_FWD:
            begin
                left_next = RAT_W'(262144);
                right_next = RAT_W'(262144);
            end
            RSEL_PID:
            begin
                left_next = RAT_W'(196608) - ctl_c;
                right_next = RAT_W'(196608) + ctl_c;
            end
            default:
            begin
                left_next = left_reg;
                right_next = right_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg <= '0;
            last_error_reg <= '0;
            left_reg <= '0;
            right_reg <= '0;
            cla_reg <= 1'b0;
            cra_reg <= 1'b0;
            tl_reg <= 1'b0;
            tr_reg <= 1'b0;
            circ_reg <= 1'b0;
            head_reg <= HEAD_NONE;
        end
        else if (cmd.commit)
        begin
            if (rsel == RSEL_PID)
            begin
                error_sum_reg <= s_new_reg;
                last_error_reg <= e_reg;
            end
            left_reg <= left_next;
            right_reg <= right_next;
            cla_reg <= cla_next;
            cra_reg <= cra_next;
            tl_reg <= tl_next;
            tr_reg <= tr_next;
            circ_reg <= circ_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            left_velocity <= VEL_W'(left_next) * VEL_W'(12);
            right_velocity <= VEL_W'(right_next) * VEL_W'(12);
            line_class <= cls_reg;
        end
    end
endmodule
`default_nettype wire

>>> rtl/lfsc_checker.sv
// Port-level checker for the steering controller, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lfsc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [3:0] line_class
);
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_IMP(a_class_range, clk, rst_n, out_valid, line_class <= 4'd9)
    `ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && in_ready && !out_valid,
        !out_valid)
endmodule

bind line_follow_steering_controller lfsc_checker u_lfsc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .line_class(out_ch.line_class)
);
`default_nettype wire
